[sv/npd_pkg.sv]
// Shared types and constants for the nearest point directory.
// Used by the top-level core; depends on nothing else.
package npd_pkg;

	localparam int ADDR_W    = 32;
	localparam int MAXD_W    = 23;
	localparam int IDX_OUT_W = 6;
	localparam int STAT_W    = 3;

	localparam logic [MAXD_W-1:0] MAXD_RESET = 23'd2560000;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_QUERY = 1'b1
	} npd_op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_ADDED = 3'd0,
		STAT_FULL  = 3'd1,
		STAT_FOUND = 3'd2,
		STAT_NONE  = 3'd3,
		STAT_EMPTY = 3'd4
	} npd_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_RESP
	} npd_state_t;

endpackage

[sv/npd_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// Standalone; no package needed.
module npd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/npd_dist.sv]
// Pipelined squared-distance unit: difference and magnitude, squares, sum.
// Three register stages; standalone, no package needed.
module npd_dist #(
	parameter int W = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic signed [W-1:0] entry_lat,
	input  logic signed [W-1:0] entry_long,
	input  logic signed [W-1:0] query_lat,
	input  logic signed [W-1:0] query_long,
	output logic                out_vld,
	output logic [2*W:0]        d2
);

	logic [W:0]     dlat, dlong, nlat, nlong;
	logic [W-1:0]   mag_lat_s1, mag_long_s1;
	logic [2*W-1:0] sq_lat_s2, sq_long_s2;
	logic [2*W:0]   d2_s3;
	logic           vld_s1, vld_s2, vld_s3;

	// Difference of two W-bit values needs W+1 bits; its magnitude fits W bits.
	assign dlat  = {entry_lat[W-1], entry_lat} - {query_lat[W-1], query_lat};
	assign dlong = {entry_long[W-1], entry_long} - {query_long[W-1], query_long};
	assign nlat  = dlat[W] ? (~dlat + 1'b1) : dlat;
	assign nlong = dlong[W] ? (~dlong + 1'b1) : dlong;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		mag_lat_s1  <= nlat[W-1:0];
		mag_long_s1 <= nlong[W-1:0];
		sq_lat_s2   <= mag_lat_s1 * mag_lat_s1;
		sq_long_s2  <= mag_long_s1 * mag_long_s1;
		d2_s3       <= {1'b0, sq_lat_s2} + {1'b0, sq_long_s2};
	end

	assign out_vld = vld_s3;
	assign d2      = d2_s3;

endmodule

[sv/nearest_point_directory_core.sv]
// Top level of the nearest point directory: command FSM, entry RAM, distance
// pipeline and best-match tracking. Depends on npd_pkg, npd_ram, npd_dist.
//
//   channel  handshake              payload
//   -------  ---------------------  ---------------------------------------------
//   command  start / busy           operation, pos_lat, pos_long, entry_address
//   result   done (1-cycle strobe)  status, found_address, found_index
//   config   cfg_valid / cfg_ready  cfg_data (max_distance)
//
// An add's result strobes in the cycle after acceptance, and a new command may
// be accepted in that same cycle. A query over N stored entries scans them in
// order: the entry RAM read port delivers one entry per cycle, then the
// three-stage distance pipeline drains and one more RAM read fetches the
// winning address. An empty-table query strobes its result in the cycle after
// acceptance. Reset clears the entry count and restores max_distance; the RAM
// needs no clearing since only entries below the count are ever read.
// Results cannot be held off by the receiver; cfg_ready is always high.
module nearest_point_directory_core
	import npd_pkg::*;
#(
	parameter int TABLE_DEPTH = 64,
	parameter int COORD_WIDTH = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic signed [COORD_WIDTH-1:0] pos_lat,
	input  logic signed [COORD_WIDTH-1:0] pos_long,
	input  logic [ADDR_W-1:0]            entry_address,
	output logic                         done,
	output logic [STAT_W-1:0]            status,
	output logic [ADDR_W-1:0]            found_address,
	output logic [IDX_OUT_W-1:0]         found_index,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [MAXD_W-1:0]            cfg_data
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int D2_W  = 2 * COORD_WIDTH + 1;
	localparam int CMP_W = (D2_W > 2 * MAXD_W) ? D2_W : 2 * MAXD_W;
	localparam int ROW_W = 2 * COORD_WIDTH + ADDR_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	npd_state_t state_q, state_d;

	logic [MAXD_W-1:0]   max_distance_q;
	logic [2*MAXD_W-1:0] max_sq_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    rd_idx_q, rcnt_q, best_idx_q, last_idx;
	logic [CMP_W-1:0]    best_q, cand, bound;
	logic                hit_q, take, rd_vld_s1, done_q;
	logic signed [COORD_WIDTH-1:0] q_lat_q, q_long_q;
	npd_status_t         status_q;
	logic [ADDR_W-1:0]   found_address_q;
	logic [IDX_OUT_W-1:0] found_index_q;

	logic             accept, is_add, full, last_issue, last_res;
	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [ROW_W-1:0] ram_wdata, ram_rdata;
	logic             dist_vld;
	logic [D2_W-1:0]  dist_d2;

	assign accept     = start && !busy;
	assign is_add     = (operation == OP_ADD);
	assign full       = (count_q == DEPTH_C);
	assign last_idx   = IDX_W'(count_q - 1'b1);
	assign last_issue = (rd_idx_q == last_idx);
	assign last_res   = (rcnt_q == last_idx);
	assign busy       = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;

	// Row layout: {address, longitude, latitude}
	assign ram_wdata = {entry_address, pos_long, pos_lat};

	npd_ram #(
		.WIDTH(ROW_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	npd_dist #(
		.W(COORD_WIDTH)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (rd_vld_s1),
		.entry_lat (ram_rdata[COORD_WIDTH-1:0]),
		.entry_long(ram_rdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.query_lat (q_lat_q),
		.query_long(q_long_q),
		.out_vld   (dist_vld),
		.d2        (dist_d2)
	);

	// Strictly-below compare keeps the lowest index on ties.
	assign cand  = CMP_W'(dist_d2);
	assign bound = hit_q ? best_q : CMP_W'(max_sq_q);
	assign take  = dist_vld && (cand < bound);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Reads and writes never overlap: the table is only written from idle.
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = rd_idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_add) begin
						ram_we = !full;
					end else if (count_q != '0) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				ram_re = 1'b1;
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (dist_vld && last_res) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				ram_re    = 1'b1;
				ram_raddr = best_idx_q;
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distance_q <= MAXD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_distance_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			done_q    <= 1'b0;
			hit_q     <= 1'b0;
			rd_idx_q  <= '0;
			rcnt_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_IDLE && accept) begin
				if (is_add) begin
					done_q <= 1'b1;
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
				end else if (count_q == '0) begin
					done_q <= 1'b1;
				end else begin
					rd_idx_q <= '0;
					rcnt_q   <= '0;
					hit_q    <= 1'b0;
				end
			end
			if (state_q == ST_SCAN && !last_issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (dist_vld) begin
				rcnt_q <= rcnt_q + 1'b1;
			end
			if (take) begin
				hit_q <= 1'b1;
			end
			if (state_q == ST_RESP) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			q_lat_q         <= pos_lat;
			q_long_q        <= pos_long;
			max_sq_q        <= max_distance_q * max_distance_q;
			found_address_q <= '0;
			found_index_q   <= '0;
			if (is_add) begin
				status_q <= full ? STAT_FULL : STAT_ADDED;
			end else begin
				status_q <= STAT_EMPTY;
			end
		end
		if (take) begin
			best_q     <= cand;
			best_idx_q <= rcnt_q;
		end
		if (state_q == ST_RESP) begin
			status_q        <= hit_q ? STAT_FOUND : STAT_NONE;
			found_address_q <= hit_q ? ram_rdata[ROW_W-1 -: ADDR_W] : '0;
			found_index_q   <= hit_q ? IDX_OUT_W'(best_idx_q) : '0;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign found_address = found_address_q;
	assign found_index   = found_index_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe outside idle");

	a_dist_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		dist_vld |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("distance result outside a scan");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count beyond table depth");

	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_add && !full) |=> (count_q == $past(count_q) + 1'b1))
		else $error("accepted add did not advance count");

	a_found_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == STAT_FOUND) |-> (CNT_W'(best_idx_q) < count_q))
		else $error("found index beyond stored entries");

endmodule
